// ===== rtl/core/stick_vector_heading_degrees_macros.svh =====
// Assertion macros shared by the heading block's checker.
// Depends on nothing; include by bare file name.
`ifndef STICK_VECTOR_HEADING_DEGREES_MACROS_SVH
`define STICK_VECTOR_HEADING_DEGREES_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SVHD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading check failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define SVHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading check failed: next-cycle implication");

`endif

// ===== rtl/core/svhd_pkg.sv =====
// Types, constants and the arctangent table for the stick heading block.
// Depends on nothing; used by every module of the block.
package svhd_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int FRAC_BITS_DEF         = 7;

    localparam int TABLE_LEN = 24;
    localparam int ANG_FRAC  = 16;
    localparam int PRESCALE  = 14;

    localparam int IN_W  = 16;
    localparam int D_W   = 34;
    localparam int Z_W   = 25;
    localparam int TAB_W = 22;
    localparam int A_W   = 16;
    localparam int H_W   = 18;
    localparam int CNT_W = $clog2(TABLE_LEN);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // atan(2^-i) in degrees, 16 fraction bits
    localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    typedef enum logic [2:0] {
        CLS_ZERO    = 3'd0,
        CLS_POS_Y   = 3'd1,
        CLS_NEG_Y   = 3'd2,
        CLS_POS_X   = 3'd3,
        CLS_NEG_X   = 3'd4,
        CLS_GENERAL = 3'd5
    } svhd_cls_t;

    typedef struct packed {
        svhd_cls_t       cls;
        logic            x_neg;
        logic            y_neg;
        logic [IN_W-1:0] ax;
        logic [IN_W-1:0] ay;
    } svhd_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } svhd_qstat_t;

endpackage

// ===== rtl/core/svhd_front.sv =====
// Front end: takes input words, sorts them into axis, zero or general cases.
// Depends on svhd_pkg; feeds svhd_queue.
module svhd_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [svhd_pkg::IN_W-1:0] x_value,
    input  logic signed [svhd_pkg::IN_W-1:0] y_value,
    input  svhd_pkg::svhd_qstat_t         qstat,
    output logic                          push,
    output svhd_pkg::svhd_item_t          push_item
);
    import svhd_pkg::*;

    logic x_zero;
    logic y_zero;

    assign in_stall = qstat.full;
    assign push     = in_valid && !qstat.full;
    assign x_zero   = (x_value == '0);
    assign y_zero   = (y_value == '0);

    always_comb
    begin
        push_item.x_neg = x_value[IN_W-1];
        push_item.y_neg = y_value[IN_W-1];
        push_item.ax    = x_value[IN_W-1] ? IN_W'(-x_value) : IN_W'(x_value);
        push_item.ay    = y_value[IN_W-1] ? IN_W'(-y_value) : IN_W'(y_value);
        priority if (x_zero && y_zero)
        begin
            push_item.cls = CLS_ZERO;
        end
        else if (x_zero)
        begin
            push_item.cls = y_value[IN_W-1] ? CLS_NEG_Y : CLS_POS_Y;
        end
        else if (y_zero)
        begin
            push_item.cls = x_value[IN_W-1] ? CLS_NEG_X : CLS_POS_X;
        end
        else
        begin
            push_item.cls = CLS_GENERAL;
        end
    end

endmodule

// ===== rtl/core/svhd_queue.sv =====
// Short queue of classified words between the front and back ends.
// Depends on svhd_pkg.
module svhd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  svhd_pkg::svhd_item_t  push_item,
    input  logic                  pop,
    output svhd_pkg::svhd_item_t  pop_item,
    output svhd_pkg::svhd_qstat_t qstat
);
    import svhd_pkg::*;

    svhd_item_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/svhd_back.sv =====
// Back end: iterative vectoring rotator, quadrant placement and result register.
// Depends on svhd_pkg; drains svhd_queue.
module svhd_back #(
    parameter int CORDIC_ITERATIONS = svhd_pkg::CORDIC_ITERATIONS_DEF,
    parameter int FRAC_BITS         = svhd_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  svhd_pkg::svhd_qstat_t            qstat,
    input  svhd_pkg::svhd_item_t             pop_item,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [svhd_pkg::IN_W-1:0] heading,
    output logic                             held
);
    import svhd_pkg::*;

    localparam int ITER_N = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
    localparam int RSHIFT = ANG_FRAC - FRAC_BITS;
    localparam logic [CNT_W-1:0]     LAST  = CNT_W'(ITER_N - 1);
    localparam logic signed [Z_W-1:0] LIM  = Z_W'(90 << ANG_FRAC);
    localparam logic [Z_W-1:0]       RND   = Z_W'(1 << (RSHIFT - 1));
    localparam logic signed [H_W-1:0] FULL  = H_W'(180 << FRAC_BITS);
    localparam logic signed [H_W-1:0] RIGHT = H_W'(90 << FRAC_BITS);
    localparam logic signed [H_W-1:0] HMAX  = H_W'(32767);
    localparam logic signed [H_W-1:0] HMIN  = H_W'(-32768);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ROT  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_OUT  = 4'b1000
    } svhd_state_t;

    svhd_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         iter_reg, iter_next;
    logic signed [D_W-1:0]    u_reg, u_next;
    logic signed [D_W-1:0]    v_reg, v_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [A_W-1:0]           a_reg, a_next;
    svhd_cls_t                cls_reg, cls_next;
    logic                     x_neg_reg, x_neg_next;
    logic                     y_neg_reg, y_neg_next;
    logic signed [IN_W-1:0]   last_reg, last_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [IN_W-1:0]   heading_reg, heading_next;
    logic                     held_reg, held_next;

    logic signed [D_W-1:0]    du;
    logic signed [D_W-1:0]    dv;
    logic signed [Z_W-1:0]    tab;
    logic [Z_W-1:0]           z_clamp;
    logic [Z_W-1:0]           z_round;
    logic signed [H_W-1:0]    a_ext;
    logic signed [H_W-1:0]    h_raw;
    logic signed [IN_W-1:0]   h_sat;
    logic                     out_free;

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;
    assign held      = held_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign du  = v_reg >>> iter_reg;
    assign dv  = u_reg >>> iter_reg;
    assign tab = Z_W'(ATAN_TAB[iter_reg]);

    always_comb
    begin
        priority if (z_reg[Z_W-1])
        begin
            z_clamp = '0;
        end
        else if (z_reg > LIM)
        begin
            z_clamp = LIM;
        end
        else
        begin
            z_clamp = z_reg;
        end
        z_round = z_clamp + RND;
    end

    // pick the heading for each class, placing the first-quadrant angle in its quadrant, then saturate
    always_comb
    begin
        a_ext = H_W'(a_reg);
        unique case (cls_reg)
            CLS_ZERO:    h_raw = H_W'(last_reg);
            CLS_POS_Y:   h_raw = '0;
            CLS_NEG_Y:   h_raw = FULL;
            CLS_POS_X:   h_raw = RIGHT;
            CLS_NEG_X:   h_raw = -RIGHT;
            CLS_GENERAL:
            begin
                if (y_neg_reg)
                begin
                    h_raw = x_neg_reg ? (a_ext - FULL) : (FULL - a_ext);
                end
                else
                begin
                    h_raw = x_neg_reg ? -a_ext : a_ext;
                end
            end
            default:     h_raw = '0;
        endcase
        priority if (h_raw > HMAX)
        begin
            h_sat = IN_W'(HMAX);
        end
        else if (h_raw < HMIN)
        begin
            h_sat = IN_W'(HMIN);
        end
        else
        begin
            h_sat = IN_W'(h_raw);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        z_next         = z_reg;
        a_next         = a_reg;
        cls_next       = cls_reg;
        x_neg_next     = x_neg_reg;
        y_neg_next     = y_neg_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        heading_next   = heading_reg;
        held_next      = held_reg;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    cls_next   = pop_item.cls;
                    x_neg_next = pop_item.x_neg;
                    y_neg_next = pop_item.y_neg;
                    u_next     = D_W'({pop_item.ay, {PRESCALE{1'b0}}});
                    v_next     = D_W'({pop_item.ax, {PRESCALE{1'b0}}});
                    z_next     = '0;
                    iter_next  = '0;
                    state_next = (pop_item.cls == CLS_GENERAL) ? ST_ROT : ST_OUT;
                end
            end
            ST_ROT:
            begin
                if (!v_reg[D_W-1])
                begin
                    u_next = u_reg + du;
                    v_next = v_reg - dv;
                    z_next = z_reg + tab;
                end
                else
                begin
                    u_next = u_reg - du;
                    v_next = v_reg + dv;
                    z_next = z_reg - tab;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                a_next     = A_W'(z_round >> RSHIFT);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    heading_next   = h_sat;
                    held_next      = (cls_reg == CLS_ZERO);
                    last_next      = h_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg       <= u_next;
        v_reg       <= v_next;
        z_reg       <= z_next;
        a_reg       <= a_next;
        cls_reg     <= cls_next;
        x_neg_reg   <= x_neg_next;
        y_neg_reg   <= y_neg_next;
        heading_reg <= heading_next;
        held_reg    <= held_next;
    end

endmodule

// ===== rtl/core/stick_vector_heading_degrees.sv =====
// Top level of the stick heading block: front end, queue and back end.
// Depends on svhd_pkg, svhd_front, svhd_queue and svhd_back.
//
// Gives the heading of an (x, y) vector from the +y axis, positive toward +x,
// in degrees with FRAC_BITS fraction bits. One result word per input word, in
// order. A vector off both axes is dequeued, run through min(CORDIC_ITERATIONS,
// 24) rotations of the single shared shift-add rotator, rounded to an angle and
// then loaded into the result register once the output is not stalled. Axis and
// zero vectors skip the rotations and rounding. A two-word queue lets the input
// side keep taking words while the rotator is busy. A zero vector repeats the
// last heading given (0 after reset) with held set.
module stick_vector_heading_degrees #(
    parameter int CORDIC_ITERATIONS = svhd_pkg::CORDIC_ITERATIONS_DEF,
    parameter int FRAC_BITS         = svhd_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [svhd_pkg::IN_W-1:0] x_value,
    input  logic signed [svhd_pkg::IN_W-1:0] y_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [svhd_pkg::IN_W-1:0] heading,
    output logic                             held
);
    import svhd_pkg::*;

    logic        push;
    svhd_item_t  push_item;
    logic        pop;
    svhd_item_t  pop_item;
    svhd_qstat_t qstat;

    svhd_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_value   (x_value),
        .y_value   (y_value),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    svhd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    svhd_back #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .FRAC_BITS         (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .heading   (heading),
        .held      (held)
    );

endmodule

// ===== rtl/core/svhd_checker.sv =====
// Port-level checks for the stick heading block, bound to its top level.
// Depends on svhd_pkg and stick_vector_heading_degrees_macros.svh.
`include "stick_vector_heading_degrees_macros.svh"

module svhd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic signed [svhd_pkg::IN_W-1:0] x_value,
    input logic signed [svhd_pkg::IN_W-1:0] y_value,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [svhd_pkg::IN_W-1:0] heading,
    input logic                             held
);
    import svhd_pkg::*;

    logic                   in_acc;
    logic                   out_acc;
    logic [3:0]             pending_reg, pending_next;
    logic signed [IN_W-1:0] seen_reg, seen_next;
    logic [2*IN_W-1:0]      in_word;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_word = {x_value, y_value};

    always_comb
    begin
        pending_next = pending_reg + {3'b0, in_acc} - {3'b0, out_acc};
        seen_next    = out_acc ? heading : seen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            seen_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            seen_reg    <= seen_next;
        end
    end

    `SVHD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(heading) && $stable(held))
    `SVHD_ASSERT_IMPLIES(a_held_repeats, clk, rst_n, out_valid && held, heading == seen_reg)
    `SVHD_ASSERT_IMPLIES(a_no_spurious, clk, rst_n, out_valid, pending_reg != 4'd0)
    `SVHD_ASSERT_IMPLIES(a_in_flight, clk, rst_n, in_acc, pending_reg <= 4'd3)
    `SVHD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_word))

endmodule

bind stick_vector_heading_degrees svhd_checker u_svhd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_value   (x_value),
    .y_value   (y_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .heading   (heading),
    .held      (held)
);

// ===== tb/stick_vector_heading_degrees_test.sv =====
// Self-checking bench for stick_vector_heading_degrees: directed table, then random vectors.
// Depends on svhd_pkg and the block's RTL; a built-in CORDIC predictor supplies each heading not typed in the table.
module stick_vector_heading_degrees_test;

    import svhd_pkg::*;

    localparam int ITERS        = CORDIC_ITERATIONS_DEF;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int HALF_TURN    = 180 << FRAC;
    localparam int QUARTER_TURN = 90 << FRAC;
    localparam int RANDOM_WORDS = 800;
    localparam int HOLD_OFF     = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    localparam longint ATAN_DEG_FIX [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [IN_W-1:0] heading;
        logic                   held;
    } heading_word_t;

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic                   typed;
        logic signed [IN_W-1:0] heading;
        logic                   held;
    } directed_row_t;

    typedef enum int {
        VK_FULL,
        VK_SMALL,
        VK_AXIS,
        VK_ZERO,
        VK_EXTREME,
        VK_NEAR_AXIS
    } vec_kind_t;

    localparam int DIRECTED_LEN = 25;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{16'sd0,      16'sd0,      1'b1, 16'sd0,      1'b1},
        '{16'sd0,      16'sd32767,  1'b1, 16'sd0,      1'b0},
        '{16'sd0,      -16'sd32768, 1'b1, 16'sd23040,  1'b0},
        '{16'sd32767,  16'sd0,      1'b1, 16'sd11520,  1'b0},
        '{16'sd0,      16'sd0,      1'b1, 16'sd11520,  1'b1},
        '{-16'sd32768, 16'sd0,      1'b1, -16'sd11520, 1'b0},
        '{16'sd0,      16'sd0,      1'b1, -16'sd11520, 1'b1},
        '{16'sd0,      16'sd1,      1'b1, 16'sd0,      1'b0},
        '{16'sd0,      -16'sd1,     1'b1, 16'sd23040,  1'b0},
        '{16'sd1,      16'sd0,      1'b1, 16'sd11520,  1'b0},
        '{-16'sd1,     16'sd0,      1'b1, -16'sd11520, 1'b0},
        '{16'sd32767,  16'sd32767,  1'b0, 16'sd0,      1'b0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'sd0,      1'b0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{16'sd1,      16'sd1,      1'b0, 16'sd0,      1'b0},
        '{-16'sd1,     16'sd1,      1'b0, 16'sd0,      1'b0},
        '{16'sd1,      -16'sd1,     1'b0, 16'sd0,      1'b0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'sd0,      1'b0},
        '{16'sd1,      16'sd32767,  1'b0, 16'sd0,      1'b0},
        '{16'sd32767,  16'sd1,      1'b0, 16'sd0,      1'b0},
        '{-16'sd1,     -16'sd32768, 1'b0, 16'sd0,      1'b0},
        '{-16'sd32768, -16'sd1,     1'b0, 16'sd0,      1'b0},
        '{16'sd0,      16'sd0,      1'b0, 16'sd0,      1'b0},
        '{-16'sd12345, 16'sd23456,  1'b0, 16'sd0,      1'b0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic signed [IN_W-1:0] x_value = '0;
    logic signed [IN_W-1:0] y_value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [IN_W-1:0] heading;
    logic                   held;

    heading_word_t          pending_headings [$];
    logic signed [IN_W-1:0] prior_heading = '0;
    int                     fail_count = 0;
    int                     words_sent = 0;
    int                     zero_words = 0;
    int                     headings_checked = 0;
    int                     cycle_count = 0;

    stick_vector_heading_degrees dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_value   (x_value),
        .y_value   (y_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .heading   (heading),
        .held      (held)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int cordic_quadrant_deg(input longint u_in, input longint v_in);
        longint u;
        longint v;
        longint z;
        longint du;
        longint dv;
        longint lim;
        z   = 0;
        lim = longint'(90) << ANG_FRAC;
        u   = u_in <<< PRESCALE;
        v   = v_in <<< PRESCALE;
        for (int i = 0; i < ITERS && i < TABLE_LEN; i++)
        begin
            du = v >>> i;
            dv = u >>> i;
            if (v >= 0)
            begin
                u = u + du;
                v = v - dv;
                z = z + ATAN_DEG_FIX[i];
            end
            else
            begin
                u = u - du;
                v = v + dv;
                z = z - ATAN_DEG_FIX[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > lim)
            z = lim;
        z = z + (longint'(1) << (ANG_FRAC - FRAC - 1));
        return int'(z >>> (ANG_FRAC - FRAC));
    endfunction

    function automatic heading_word_t predict_heading(input logic signed [IN_W-1:0] xv,
                                                      input logic signed [IN_W-1:0] yv);
        heading_word_t w;
        int            h;
        int            a;
        longint        ax;
        longint        ay;
        if (xv == 0 && yv == 0)
        begin
            w.heading = prior_heading;
            w.held    = 1'b1;
            return w;
        end
        if (xv == 0)
            h = (yv > 0) ? 0 : HALF_TURN;
        else if (yv == 0)
            h = (xv > 0) ? QUARTER_TURN : -QUARTER_TURN;
        else
        begin
            ax = (xv < 0) ? -longint'(xv) : longint'(xv);
            ay = (yv < 0) ? -longint'(yv) : longint'(yv);
            a  = cordic_quadrant_deg(ay, ax);
            if (yv > 0)
                h = (xv > 0) ? a : -a;
            else
                h = (xv > 0) ? (HALF_TURN - a) : -(HALF_TURN - a);
        end
        if (h > 32767)
            h = 32767;
        if (h < -32768)
            h = -32768;
        prior_heading = h[IN_W-1:0];
        w.heading     = prior_heading;
        w.held        = 1'b0;
        return w;
    endfunction

    // Offer one word and hold it until accepted.
    task automatic send_word(input logic signed [IN_W-1:0] xv, input logic signed [IN_W-1:0] yv,
                             input logic typed, input heading_word_t typed_word);
        heading_word_t model_word;
        in_valid <= 1'b1;
        x_value  <= xv;
        y_value  <= yv;
        do
            @(posedge clk);
        while (in_stall);
        model_word = predict_heading(xv, yv);
        pending_headings.push_back(typed ? typed_word : model_word);
        words_sent++;
        if (xv == 0 && yv == 0)
            zero_words++;
    endtask

    function automatic logic signed [IN_W-1:0] extreme_component();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic pick_vector(output logic signed [IN_W-1:0] xv,
                               output logic signed [IN_W-1:0] yv);
        int        roll;
        vec_kind_t kind;
        logic signed [IN_W-1:0] big;
        logic signed [IN_W-1:0] tiny;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            kind = VK_FULL;
        else if (roll < 60)
            kind = VK_SMALL;
        else if (roll < 70)
            kind = VK_AXIS;
        else if (roll < 78)
            kind = VK_ZERO;
        else if (roll < 85)
            kind = VK_EXTREME;
        else
            kind = VK_NEAR_AXIS;
        big  = IN_W'($urandom());
        tiny = IN_W'(int'($urandom_range(0, 6)) - 3);
        case (kind)
            VK_FULL:
            begin
                xv = IN_W'($urandom());
                yv = IN_W'($urandom());
            end
            VK_SMALL:
            begin
                xv = IN_W'(int'($urandom_range(0, 16)) - 8);
                yv = IN_W'(int'($urandom_range(0, 16)) - 8);
            end
            VK_AXIS:
            begin
                xv = $urandom_range(0, 1) ? big : '0;
                yv = (xv == 0) ? big : '0;
            end
            VK_ZERO:
            begin
                xv = '0;
                yv = '0;
            end
            VK_EXTREME:
            begin
                xv = extreme_component();
                yv = extreme_component();
            end
            default:
            begin
                xv = $urandom_range(0, 1) ? big : tiny;
                yv = (xv == big) ? tiny : big;
            end
        endcase
    endtask

    always @(posedge clk)
    begin : check_results
        heading_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_headings.size() == 0)
            begin
                $error("unexpected result word: heading %0d, held %0d", heading, held);
                fail_count++;
            end
            else
            begin
                want = pending_headings.pop_front();
                headings_checked++;
                if (heading !== want.heading)
                begin
                    $error("heading mismatch: expected %0d, actual %0d", want.heading, heading);
                    fail_count++;
                end
                if (held !== want.held)
                begin
                    $error("held mismatch: expected %0d, actual %0d", want.held, held);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!hold_done && headings_checked >= 60)
            begin
                out_stall <= 1'b1;
                hold_left = HOLD_OFF - 1;
                hold_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        heading_word_t          typed_word;
        logic signed [IN_W-1:0] xv;
        logic signed [IN_W-1:0] yv;
        int                     burst_len;
        int                     gap;
        int                     random_sent;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_LEN; r++)
        begin
            typed_word.heading = DIRECTED_ROWS[r].heading;
            typed_word.held    = DIRECTED_ROWS[r].held;
            send_word(DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].typed, typed_word);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        random_sent = 0;
        typed_word  = '0;
        while (random_sent < RANDOM_WORDS)
        begin
            burst_len = $urandom_range(1, 24);
            for (int b = 0; b < burst_len && random_sent < RANDOM_WORDS; b++)
            begin
                pick_vector(xv, yv);
                send_word(xv, yv, 1'b0, typed_word);
                random_sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending_headings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d vectors (%0d directed, %0d zero vectors), checked %0d headings,",
                 words_sent, DIRECTED_LEN, zero_words, headings_checked);
        $display("with bursty input, patterned output stalls and one %0d-cycle hold-off.",
                 HOLD_OFF);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
